### design/aes_pkg.sv
// Package for the AES-128 block encryptor: payload word types, register
// indexes, chaining mode codes and the S-box/xtime helper functions.
// No dependencies.
package aes_pkg;

  typedef struct packed {
    logic [63:0] text_high;
    logic [63:0] text_low;
    logic        first_block;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [2:0] REG_KEY_LOW    = 3'd1;
  localparam logic [2:0] REG_IV_HIGH    = 3'd2;
  localparam logic [2:0] REG_IV_LOW     = 3'd3;
  localparam logic [2:0] REG_CHAIN_MODE = 3'd4;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CFB = 2'd2;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/aes_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module aes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/aes128_block_encrypt_modes.sv
// AES-128 encryptor, ECB / CBC / CFB-128, with round keys held in a RAM.
// Each block is taken in IDLE; for each of the 11 round keys, RD_LO and
// RD_HI read its two 64-bit halves from the RAM and ROUND applies the round,
// then DONE offers the output word; a message-start block first runs key
// expansion. A new block waits until the last output word is taken.
// Reset: synchronous; clears config, chain value and control, not key RAM.
module aes128_block_encrypt_modes #(
  parameter int ROUND_COUNT = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  aes_pkg::aes_in_t    in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output aes_pkg::aes_out_t   out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import aes_pkg::*;

  localparam int KeyWords = 2 * ROUND_COUNT;
  localparam int AW = $clog2(KeyWords);
  localparam int RW = $clog2(ROUND_COUNT + 1);

  typedef enum logic [2:0] {
    IDLE, EXPAND, RD_LO, RD_HI, ROUND, DONE
  } state_t;

  state_t state;
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [1:0]  chain_mode;
  logic [127:0] chain, text, st, kx;
  logic [63:0] rk;  // high half of the current round key
  logic [RW-1:0] rnd;
  logic [7:0] rcon;
  logic        wr_half;  // expansion: which half to write next
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_wdata, ram_rdata;

  aes_ram #(.WIDTH(64), .DEPTH(KeyWords)) u_keys (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Next round key from the current one
  logic [31:0] w0, w1, w2, w3, tw;
  logic [127:0] kx_next;
  always_comb begin
    w0 = kx[127:96]; w1 = kx[95:64]; w2 = kx[63:32]; w3 = kx[31:0];
    tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tw; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    kx_next = {w0, w1, w2, w3};
  end

  // One cipher round: SubBytes, ShiftRows, optional MixColumns
  logic [7:0] sb [16];
  logic [7:0] ss [16];
  logic [127:0] sr, mc;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = st[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[4*c+r] = sbox(sb[4*((c+r)%4)+r]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      sr[127-8*i -: 8] = ss[i];
    end
    for (int c = 0; c < 4; c++) begin
      mc[127-32*c -: 8] = ss[4*c] ^ (ss[4*c]^ss[4*c+1]^ss[4*c+2]^ss[4*c+3])
                          ^ xtime(ss[4*c] ^ ss[4*c+1]);
      mc[119-32*c -: 8] = ss[4*c+1] ^ (ss[4*c]^ss[4*c+1]^ss[4*c+2]^ss[4*c+3])
                          ^ xtime(ss[4*c+1] ^ ss[4*c+2]);
      mc[111-32*c -: 8] = ss[4*c+2] ^ (ss[4*c]^ss[4*c+1]^ss[4*c+2]^ss[4*c+3])
                          ^ xtime(ss[4*c+2] ^ ss[4*c+3]);
      mc[103-32*c -: 8] = ss[4*c+3] ^ (ss[4*c]^ss[4*c+1]^ss[4*c+2]^ss[4*c+3])
                          ^ xtime(ss[4*c+3] ^ ss[4*c]);
    end
  end

  // Cipher input by mode
  logic [127:0] blk_in;
  always_comb begin
    case (chain_mode)
      MODE_CBC: blk_in = text ^ chain;
      MODE_CFB: blk_in = chain;
      default:  blk_in = text;
    endcase
  end

  // RAM port control: write during expansion, read round keys otherwise
  always_comb begin
    ram_we    = (state == EXPAND);
    ram_wdata = wr_half ? kx[63:0] : kx[127:64];
    ram_addr  = AW'({rnd, wr_half});
    if (state != EXPAND) begin
      ram_addr = AW'({rnd, 1'b0});
      if (state == RD_HI) begin
        ram_addr = AW'({rnd, 1'b1});
      end
    end
  end

  assign in_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; out_valid <= 1'b0;
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      chain_mode <= MODE_ECB; chain <= '0; rnd <= '0; wr_half <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH:   key_high <= cfg_data;
          REG_KEY_LOW:    key_low <= cfg_data;
          REG_IV_HIGH:    iv_high <= cfg_data;
          REG_IV_LOW:     iv_low <= cfg_data;
          REG_CHAIN_MODE: chain_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          rnd <= '0;
          wr_half <= 1'b0;
          if (in_valid) begin
            text <= {in_word.text_high, in_word.text_low};
            if (in_word.first_block) begin
              chain <= {iv_high, iv_low};
              kx    <= {key_high, key_low};
              rcon  <= 8'h01;
              state <= EXPAND;
            end else begin
              state <= RD_LO;
            end
          end
        end
        // Two writes per round key, then derive the next key
        EXPAND: begin
          wr_half <= ~wr_half;
          if (wr_half) begin
            kx <= kx_next;
            rcon <= xtime(rcon);
            if (rnd == RW'(ROUND_COUNT - 1)) begin
              rnd <= '0;
              state <= RD_LO;
            end else begin
              rnd <= rnd + 1'b1;
            end
          end
        end
        // High half is addressed
        RD_LO: begin
          state <= RD_HI;
        end
        // High half arrives; low half is addressed
        RD_HI: begin
          rk <= ram_rdata;
          state <= ROUND;
        end
        // Low half arrives; apply this round
        ROUND: begin
          if (rnd == '0) begin
            st <= blk_in ^ {rk, ram_rdata};
          end else if (rnd == RW'(ROUND_COUNT - 1)) begin
            st <= sr ^ {rk, ram_rdata};
          end else begin
            st <= mc ^ {rk, ram_rdata};
          end
          if (rnd == RW'(ROUND_COUNT - 1)) begin
            state <= DONE;
          end else begin
            rnd <= rnd + 1'b1;
            state <= RD_LO;
          end
        end
        DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_word <= (chain_mode == MODE_CFB) ? (st ^ text) : st;
            chain    <= (chain_mode == MODE_CFB) ? (st ^ text) : st;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
